// ===== src/assert_macros.svh =====
// Assertion macros shared by the x86 prefix checker RTL.
// Depends on nothing; take in with `include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a antecedent implies a consequent in the same cycle.
`define X86PC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("x86pc assertion failed");

// Check that a condition never holds.
`define X86PC_ASSERT_NEVER(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) \
    else $error("x86pc assertion failed");

`endif

// ===== src/x86pc_pkg.sv =====
// Shared types and constants of the x86 prefix checker.
// Depends on nothing; used by all modules via scoped names.
package x86pc_pkg;

  localparam int NUM_GROUPS  = 5;
  localparam int POS_W       = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [2:0] {
    GRP_LOCK_REP = 3'd0,
    GRP_SEGMENT  = 3'd1,
    GRP_OPSIZE   = 3'd2,
    GRP_ADSIZE   = 3'd3,
    GRP_REX      = 3'd4,
    GRP_NONE     = 3'd7
  } grp_t;

  // One classified word in the queue.
  typedef struct packed {
    grp_t grp;
    logic last;
  } q_entry_t;

  // Queue status seen by front and back.
  typedef struct packed {
    logic              valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

// ===== src/x86pc_front.sv =====
// Front end: accept bytes and sort each one into a prefix group.
// Depends on x86pc_pkg.
module x86pc_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_instr_byte,
  input  logic                 in_last_byte,
  input  x86pc_pkg::q_stat_t   q_stat,
  output logic                 push,
  output x86pc_pkg::q_entry_t  push_entry
);

  function automatic x86pc_pkg::grp_t classify(input logic [7:0] b);
    x86pc_pkg::grp_t g;
    case (b)
      8'hF0, 8'hF2, 8'hF3:                      g = x86pc_pkg::GRP_LOCK_REP;
      8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65: g = x86pc_pkg::GRP_SEGMENT;
      8'h66:                                    g = x86pc_pkg::GRP_OPSIZE;
      8'h67:                                    g = x86pc_pkg::GRP_ADSIZE;
      default: begin
        if (b[7:4] == 4'h4) g = x86pc_pkg::GRP_REX;
        else                g = x86pc_pkg::GRP_NONE;
      end
    endcase
    return g;
  endfunction

  assign in_stall        = q_stat.full;
  assign push            = in_valid && !q_stat.full;
  assign push_entry.grp  = classify(in_instr_byte);
  assign push_entry.last = in_last_byte;

endmodule

// ===== src/x86pc_queue.sv =====
// Short FIFO between front and back of the x86 prefix checker.
// Depends on x86pc_pkg.
module x86pc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  x86pc_pkg::q_entry_t  push_entry,
  input  logic                 pop,
  output x86pc_pkg::q_entry_t  head,
  output x86pc_pkg::q_stat_t   stat
);

  x86pc_pkg::q_entry_t               mem_r [x86pc_pkg::QUEUE_DEPTH];
  logic [x86pc_pkg::QPTR_W-1:0]      wptr_r, rptr_r;
  logic [x86pc_pkg::QCNT_W-1:0]      count_r;

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = mem_r[rptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == x86pc_pkg::QCNT_W'(x86pc_pkg::QUEUE_DEPTH));
  assign stat.count = count_r;

endmodule

// ===== src/x86pc_back.sv =====
// Back end: track prefix groups per instruction and report on the last byte.
// Depends on x86pc_pkg.
module x86pc_back #(
  parameter int BUFFER_BYTES = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  x86pc_pkg::q_stat_t   q_stat,
  input  x86pc_pkg::q_entry_t  head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_duplicated,
  output logic                 out_in_order
);

  localparam int NG = x86pc_pkg::NUM_GROUPS;
  localparam int PW = x86pc_pkg::POS_W;

  logic                scanning_r, scanning_nxt;
  logic [NG-1:0]       seen_r, seen_nxt;
  logic                dup_r, dup_nxt;
  logic [PW-1:0]       pos_r [NG];
  logic [PW-1:0]       pos_nxt [NG];
  logic [PW-1:0]       idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                dupl_out_r, order_out_r;
  logic                ordered;

  // Non-last words never touch the output register, so they may pass it.
  assign pop = q_stat.valid && (!head.last || !out_valid_r || !out_stall);

  always_comb begin
    scanning_nxt = scanning_r;
    seen_nxt     = seen_r;
    dup_nxt      = dup_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    if (scanning_r && (idx_r < PW'(BUFFER_BYTES))) begin
      if (head.grp == x86pc_pkg::GRP_NONE || head.grp > x86pc_pkg::GRP_REX) begin
        scanning_nxt = 1'b0;
      end else begin
        if (seen_r[head.grp]) dup_nxt = 1'b1;
        seen_nxt[head.grp] = 1'b1;
        pos_nxt[head.grp]  = idx_r;
        idx_nxt            = idx_r + 1'b1;
      end
    end
  end

  always_comb begin
    ordered = 1'b1;
    for (int g = 0; g < NG - 1; g++) begin
      for (int h = g + 1; h < NG; h++) begin
        if (seen_nxt[g] && seen_nxt[h] && (pos_nxt[g] > pos_nxt[h])) ordered = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && head.last) out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r  <= 1'b1;
      seen_r      <= '0;
      dup_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      for (int g = 0; g < NG; g++) pos_r[g] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (head.last) begin
          // Clear for the next instruction.
          scanning_r <= 1'b1;
          seen_r     <= '0;
          dup_r      <= 1'b0;
          idx_r      <= '0;
          for (int g = 0; g < NG; g++) pos_r[g] <= '0;
        end else begin
          scanning_r <= scanning_nxt;
          seen_r     <= seen_nxt;
          dup_r      <= dup_nxt;
          idx_r      <= idx_nxt;
          pos_r      <= pos_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      dupl_out_r  <= dup_nxt;
      order_out_r <= ordered;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_duplicated = dupl_out_r;
  assign out_in_order   = order_out_r;

endmodule

// ===== src/x86_prefix_checker.sv =====
// x86 legacy prefix group checker, top level.
// Depends on x86pc_pkg, x86pc_front, x86pc_queue, x86pc_back, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one instruction byte per word, with
//   in_last_byte marking the final byte of the instruction buffer.
//   Result channel (out_valid / out_stall): one word per buffer, sent after
//   its last byte: out_duplicated (some prefix group repeated) and
//   out_in_order (present groups ordered by last position).
//   Throughput: one byte per cycle while in_stall is low; the back end updates
//   groups on each pop, and the front classifier and a queue with room add no bubbles.
//   A last byte is written into the queue and, once popped, its result into
//   the result register that drives out_valid.
//   The front classifies each byte and writes it into a 4-entry queue; the
//   back pops one queued word per cycle except as stalled below, and owns
//   the result register. When the receiver stalls, the held result stays put,
//   the back keeps consuming non-last bytes, and a waiting last byte stays in
//   the queue; in_stall rises only when the queue fills.
//   Reset (rst_n low, synchronous): empty the queue, drop any pending result
//   and clear all group tracking; no clearing pass is needed.
`include "assert_macros.svh"

module x86_prefix_checker #(
  parameter int BUFFER_BYTES = 15
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_instr_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_duplicated,
  output logic       out_in_order
);

  x86pc_pkg::q_stat_t  q_stat;
  x86pc_pkg::q_entry_t push_entry;
  x86pc_pkg::q_entry_t head;
  logic                push;
  logic                pop;

  // Classify and push.
  x86pc_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_instr_byte (in_instr_byte),
    .in_last_byte  (in_last_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_entry    (push_entry)
  );

  // Decouple the two sides.
  x86pc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (q_stat)
  );

  // Track groups and produce the result word.
  x86pc_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_duplicated (out_duplicated),
    .out_in_order   (out_in_order)
  );

  // Never pop an empty queue.
  `X86PC_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && (q_stat.count == '0))
  // Queue occupancy stays within its depth.
  `X86PC_ASSERT_NEVER(a_q_bound, clk, rst_n, q_stat.count > x86pc_pkg::QCNT_W'(x86pc_pkg::QUEUE_DEPTH))
  // A new result only follows a popped last byte.
  `X86PC_ASSERT_IMPL(a_res_src, clk, rst_n, $rose(out_valid), $past(pop && head.last))

endmodule
